/* hdl/lrd_pkg.sv */
// Shared types, constants and helpers for the log record deframer.
package lrd_pkg;

    // Record magic word, sent most significant byte first
    localparam logic [63:0] SYNC_WORD = 64'h17923349ab10ea9a;
    // Shift that brings the top magic byte down to the low byte
    localparam int unsigned TOP_SHIFT = 56;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_TIME   = 3'd1,
        PH_WIDTH  = 3'd2,
        PH_HEIGHT = 3'd3,
        PH_FMTLEN = 3'd4,
        PH_FMT    = 3'd5,
        PH_PLEN   = 3'd6,
        PH_DATA   = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        CLS_HUNT   = 3'd0,
        CLS_HEADER = 3'd1,
        CLS_FMT    = 3'd2,
        CLS_PLEN   = 3'd3,
        CLS_DATA   = 3'd4
    } byte_class_t;

    typedef struct packed {
        byte_class_t byte_class;
        logic [7:0]  byte_value;
        logic [63:0] timestamp;
        logic [31:0] image_width;
        logic [31:0] image_height;
        logic [31:0] format_length;
        logic [31:0] payload_length;
        logic        format_last;
        logic        record_last;
        logic        record_aborted;
    } result_t;

    // Magic byte expected at a given match position
    function automatic logic [7:0] magic_byte(input logic [2:0] pos);
        logic [5:0]  sh;
        logic [63:0] w;
        sh = 6'(TOP_SHIFT) - {pos, 3'b000};
        w  = SYNC_WORD >> sh;
        return w[7:0];
    endfunction

endpackage

/* hdl/log_record_deframer.sv */
// Top level of the log record deframer.
//
//  Channel  Dir  Ports                                        Handshake
//  s_       in   data_byte, end_of_stream                     s_valid / s_ready
//  m_       out  byte_class, byte_value, header fields, flags m_valid / m_ready
//
// One item in, one item out; a new item may enter every cycle unless m_ready stalls the output.
// Each item passes through two registers: input register, then result register.
// Parser state advances as the input register hands its item on.
// Reset (aresetn, synchronous) clears phase, counters and header registers.
// A stall on m_ready backs up through both registers to s_ready.
module log_record_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_stream,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_byte_class,
    output logic [7:0]  m_byte_value,
    output logic [63:0] m_timestamp,
    output logic [31:0] m_image_width,
    output logic [31:0] m_image_height,
    output logic [31:0] m_format_length,
    output logic [31:0] m_payload_length,
    output logic        m_format_last,
    output logic        m_record_last,
    output logic        m_record_aborted
);

    logic             res_valid;
    logic             res_ready;
    lrd_pkg::result_t res;
    lrd_pkg::result_t out_res;

    lrd_parse u_parse (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_valid),
        .in_ready         (s_ready),
        .in_data_byte     (s_data_byte),
        .in_end_of_stream (s_end_of_stream),
        .res_valid        (res_valid),
        .res_ready        (res_ready),
        .res              (res)
    );

    lrd_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (out_res)
    );

    // Drive the result ports
    assign m_byte_class     = out_res.byte_class;
    assign m_byte_value     = out_res.byte_value;
    assign m_timestamp      = out_res.timestamp;
    assign m_image_width    = out_res.image_width;
    assign m_image_height   = out_res.image_height;
    assign m_format_length  = out_res.format_length;
    assign m_payload_length = out_res.payload_length;
    assign m_format_last    = out_res.format_last;
    assign m_record_last    = out_res.record_last;
    assign m_record_aborted = out_res.record_aborted;

    // An aborted item is reported as a hunt byte with a zero value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_record_aborted) |->
            (m_byte_class == lrd_pkg::CLS_HUNT && m_byte_value == 8'd0))
        else $error("abort item carries a byte");

    // Format end only on format text bytes
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_format_last) |-> (m_byte_class == lrd_pkg::CLS_FMT))
        else $error("format_last on non-format byte");

    // Record end only on payload length or payload data bytes
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_record_last) |->
            (m_byte_class == lrd_pkg::CLS_PLEN || m_byte_class == lrd_pkg::CLS_DATA))
        else $error("record_last on wrong byte class");

endmodule

/* hdl/lrd_parse.sv */
// Input register, parser state and per-byte result logic.
module lrd_parse (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_data_byte,
    input  logic              in_end_of_stream,
    output logic              res_valid,
    input  logic              res_ready,
    output lrd_pkg::result_t  res
);

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eos_reg;

    // Parser state
    lrd_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  sync_pos_reg, sync_pos_next;
    logic [2:0]  field_cnt_reg, field_cnt_next;
    logic [63:0] time_reg, time_next;
    logic [31:0] width_reg, width_next;
    logic [31:0] height_reg, height_next;
    logic [31:0] fmt_len_reg, fmt_len_next;
    logic [31:0] plen_reg, plen_next;
    logic [31:0] remain_reg, remain_next;

    logic advance;
    logic magic_hit;
    logic sync_last;
    logic field4_last;
    logic time_last;
    logic remain_last;
    logic [31:0] fmt_len_shift;
    logic [31:0] plen_shift;
    lrd_pkg::result_t res_next;

    assign advance   = in_valid_reg && res_ready;
    assign in_ready  = !in_valid_reg || res_ready;
    assign res_valid = in_valid_reg;

    // Hold the item until the result side takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            in_byte_reg <= in_data_byte;
            in_eos_reg  <= in_end_of_stream;
        end
    end

    // Shared decode of the current byte
    assign magic_hit     = (in_byte_reg == lrd_pkg::magic_byte(sync_pos_reg));
    assign sync_last     = (sync_pos_reg == 3'd7);
    assign field4_last   = (field_cnt_reg >= 3'd3);
    assign time_last     = (field_cnt_reg == 3'd7);
    assign remain_last   = (remain_reg[31:1] == 31'd0);
    assign fmt_len_shift = {fmt_len_reg[23:0], in_byte_reg};
    assign plen_shift    = {plen_reg[23:0], in_byte_reg};

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        if (in_eos_reg) begin
            phase_next = lrd_pkg::PH_HUNT;
        end else begin
            case (phase_reg)
                lrd_pkg::PH_HUNT: begin
                    if (magic_hit && sync_last) phase_next = lrd_pkg::PH_TIME;
                end
                lrd_pkg::PH_TIME: begin
                    if (time_last) phase_next = lrd_pkg::PH_WIDTH;
                end
                lrd_pkg::PH_WIDTH: begin
                    if (field4_last) phase_next = lrd_pkg::PH_HEIGHT;
                end
                lrd_pkg::PH_HEIGHT: begin
                    if (field4_last) phase_next = lrd_pkg::PH_FMTLEN;
                end
                lrd_pkg::PH_FMTLEN: begin
                    if (field4_last) begin
                        phase_next = (fmt_len_shift != 32'd0) ? lrd_pkg::PH_FMT
                                                              : lrd_pkg::PH_PLEN;
                    end
                end
                lrd_pkg::PH_FMT: begin
                    if (remain_last) phase_next = lrd_pkg::PH_PLEN;
                end
                lrd_pkg::PH_PLEN: begin
                    if (field4_last) begin
                        phase_next = (plen_shift != 32'd0) ? lrd_pkg::PH_DATA
                                                           : lrd_pkg::PH_HUNT;
                    end
                end
                lrd_pkg::PH_DATA: begin
                    if (remain_last) phase_next = lrd_pkg::PH_HUNT;
                end
                default: phase_next = lrd_pkg::PH_HUNT;
            endcase
        end
    end

    // Datapath and result flags
    always_comb begin
        sync_pos_next  = sync_pos_reg;
        field_cnt_next = field_cnt_reg;
        time_next      = time_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        fmt_len_next   = fmt_len_reg;
        plen_next      = plen_reg;
        remain_next    = remain_reg;

        res_next                = '0;
        res_next.byte_class     = lrd_pkg::CLS_HUNT;
        res_next.byte_value     = in_byte_reg;

        if (in_eos_reg) begin
            res_next.byte_value     = 8'd0;
            res_next.record_aborted = (phase_reg != lrd_pkg::PH_HUNT);
            sync_pos_next           = 3'd0;
            field_cnt_next          = 3'd0;
            remain_next             = 32'd0;
        end else begin
            case (phase_reg)
                lrd_pkg::PH_HUNT: begin
                    if (!magic_hit || sync_last) begin
                        sync_pos_next = 3'd0;
                    end else begin
                        sync_pos_next = sync_pos_reg + 3'd1;
                    end
                    // Clear the header on lock
                    if (magic_hit && sync_last) begin
                        field_cnt_next = 3'd0;
                        time_next      = 64'd0;
                        width_next     = 32'd0;
                        height_next    = 32'd0;
                        fmt_len_next   = 32'd0;
                        plen_next      = 32'd0;
                    end
                end
                lrd_pkg::PH_TIME: begin
                    res_next.byte_class = lrd_pkg::CLS_HEADER;
                    time_next      = {time_reg[55:0], in_byte_reg};
                    field_cnt_next = time_last ? 3'd0 : field_cnt_reg + 3'd1;
                end
                lrd_pkg::PH_WIDTH: begin
                    res_next.byte_class = lrd_pkg::CLS_HEADER;
                    width_next     = {width_reg[23:0], in_byte_reg};
                    field_cnt_next = field4_last ? 3'd0 : field_cnt_reg + 3'd1;
                end
                lrd_pkg::PH_HEIGHT: begin
                    res_next.byte_class = lrd_pkg::CLS_HEADER;
                    height_next    = {height_reg[23:0], in_byte_reg};
                    field_cnt_next = field4_last ? 3'd0 : field_cnt_reg + 3'd1;
                end
                lrd_pkg::PH_FMTLEN: begin
                    res_next.byte_class = lrd_pkg::CLS_HEADER;
                    fmt_len_next   = fmt_len_shift;
                    field_cnt_next = field4_last ? 3'd0 : field_cnt_reg + 3'd1;
                    if (field4_last) remain_next = fmt_len_shift;
                end
                lrd_pkg::PH_FMT: begin
                    res_next.byte_class = lrd_pkg::CLS_FMT;
                    if (remain_last) begin
                        remain_next          = 32'd0;
                        res_next.format_last = 1'b1;
                    end else begin
                        remain_next = remain_reg - 32'd1;
                    end
                end
                lrd_pkg::PH_PLEN: begin
                    res_next.byte_class = lrd_pkg::CLS_PLEN;
                    plen_next      = plen_shift;
                    field_cnt_next = field4_last ? 3'd0 : field_cnt_reg + 3'd1;
                    if (field4_last) begin
                        remain_next          = plen_shift;
                        res_next.record_last = (plen_shift == 32'd0);
                    end
                end
                lrd_pkg::PH_DATA: begin
                    res_next.byte_class = lrd_pkg::CLS_DATA;
                    if (remain_last) begin
                        remain_next          = 32'd0;
                        res_next.record_last = 1'b1;
                    end else begin
                        remain_next = remain_reg - 32'd1;
                    end
                end
                default: begin
                    sync_pos_next = 3'd0;
                end
            endcase
        end

        res_next.timestamp      = time_next;
        res_next.image_width    = width_next;
        res_next.image_height   = height_next;
        res_next.format_length  = fmt_len_next;
        res_next.payload_length = plen_next;
    end

    assign res = res_next;

    // Advance parser state when the result is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= lrd_pkg::PH_HUNT;
            sync_pos_reg  <= 3'd0;
            field_cnt_reg <= 3'd0;
            time_reg      <= 64'd0;
            width_reg     <= 32'd0;
            height_reg    <= 32'd0;
            fmt_len_reg   <= 32'd0;
            plen_reg      <= 32'd0;
            remain_reg    <= 32'd0;
        end else if (advance) begin
            phase_reg     <= phase_next;
            sync_pos_reg  <= sync_pos_next;
            field_cnt_reg <= field_cnt_next;
            time_reg      <= time_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            fmt_len_reg   <= fmt_len_next;
            plen_reg      <= plen_next;
            remain_reg    <= remain_next;
        end
    end

    // No byte count is left over while hunting
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == lrd_pkg::PH_HUNT) |-> (remain_reg == 32'd0))
        else $error("bytes remaining nonzero while hunting");

    // Only the timestamp field counts past four bytes
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != lrd_pkg::PH_TIME) |-> (field_cnt_reg <= 3'd3))
        else $error("field byte count out of range");

    // Sync position only moves while hunting
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != lrd_pkg::PH_HUNT) |-> (sync_pos_reg == 3'd0))
        else $error("sync position set outside hunt");

endmodule

/* hdl/lrd_out_reg.sv */
// Result register between the parser and the result channel.
module lrd_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              res_valid,
    output logic              res_ready,
    input  lrd_pkg::result_t  res,
    output logic              out_valid,
    input  logic              out_ready,
    output lrd_pkg::result_t  out_res
);

    logic             valid_reg;
    lrd_pkg::result_t res_reg;

    assign res_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    // Load a new item whenever the register is empty or being drained
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_ready) begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            res_reg <= res;
        end
    end

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the log record deframer: byte stream in, labelled bytes out.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       eos;
    } stream_item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_end_of_stream = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_byte_class;
    logic [7:0]  m_byte_value;
    logic [63:0] m_timestamp;
    logic [31:0] m_image_width;
    logic [31:0] m_image_height;
    logic [31:0] m_format_length;
    logic [31:0] m_payload_length;
    logic        m_format_last;
    logic        m_record_last;
    logic        m_record_aborted;

    log_record_deframer DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_end_of_stream  (s_end_of_stream),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_byte_class     (m_byte_class),
        .m_byte_value     (m_byte_value),
        .m_timestamp      (m_timestamp),
        .m_image_width    (m_image_width),
        .m_image_height   (m_image_height),
        .m_format_length  (m_format_length),
        .m_payload_length (m_payload_length),
        .m_format_last    (m_format_last),
        .m_record_last    (m_record_last),
        .m_record_aborted (m_record_aborted)
    );

    // Stream bytes waiting to be offered, and the labels the parser should give them
    stream_item_t      stream_q[$];
    lrd_pkg::result_t  expected_labels[$];
    logic [7:0]        record_bytes[$];
    stream_item_t      next_item;

    int pushed_count = 0;
    int sent_count = 0;
    int result_count = 0;
    int mismatches = 0;
    int sink_hold = 0;
    bit sink_held = 1'b0;

    // Parser shadow state
    logic [2:0]       sync_pos = 3'd0;
    lrd_pkg::phase_t  phase = lrd_pkg::PH_HUNT;
    logic [2:0]       field_count = 3'd0;
    logic [63:0]      time_reg = 64'd0;
    logic [31:0]      width_reg = 32'd0;
    logic [31:0]      height_reg = 32'd0;
    logic [31:0]      fmt_len_reg = 32'd0;
    logic [31:0]      pay_len_reg = 32'd0;
    logic [31:0]      remaining = 32'd0;

    // Clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Reset
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Advance the 4-byte field counter; true on the field's last byte
    function automatic bit field_end();
        if (field_count >= 3'd3) begin
            field_count = 3'd0;
            return 1'b1;
        end
        field_count = field_count + 3'd1;
        return 1'b0;
    endfunction

    // Advance the shadow parser by one item and queue the label it should produce
    task automatic deframe_byte(input logic [7:0] b_in, input logic eos);
        lrd_pkg::result_t lbl;
        logic [7:0]       b;
        b   = b_in;
        lbl = '0;
        lbl.byte_class = lrd_pkg::CLS_HUNT;
        if (eos) begin
            lbl.record_aborted = (phase != lrd_pkg::PH_HUNT);
            b           = 8'h00;
            phase       = lrd_pkg::PH_HUNT;
            sync_pos    = 3'd0;
            field_count = 3'd0;
            remaining   = 32'd0;
        end else begin
            case (phase)
                lrd_pkg::PH_HUNT: begin
                    if (b == lrd_pkg::SYNC_WORD[63 - 8 * sync_pos -: 8]) begin
                        if (sync_pos == 3'd7) begin
                            sync_pos    = 3'd0;
                            field_count = 3'd0;
                            phase       = lrd_pkg::PH_TIME;
                            time_reg    = 64'd0;
                            width_reg   = 32'd0;
                            height_reg  = 32'd0;
                            fmt_len_reg = 32'd0;
                            pay_len_reg = 32'd0;
                        end else begin
                            sync_pos = sync_pos + 3'd1;
                        end
                    end else begin
                        sync_pos = 3'd0;
                    end
                end
                lrd_pkg::PH_TIME: begin
                    lbl.byte_class = lrd_pkg::CLS_HEADER;
                    time_reg = {time_reg[55:0], b};
                    if (field_count == 3'd7) begin
                        field_count = 3'd0;
                        phase       = lrd_pkg::PH_WIDTH;
                    end else begin
                        field_count = field_count + 3'd1;
                    end
                end
                lrd_pkg::PH_WIDTH: begin
                    lbl.byte_class = lrd_pkg::CLS_HEADER;
                    width_reg = {width_reg[23:0], b};
                    if (field_end()) phase = lrd_pkg::PH_HEIGHT;
                end
                lrd_pkg::PH_HEIGHT: begin
                    lbl.byte_class = lrd_pkg::CLS_HEADER;
                    height_reg = {height_reg[23:0], b};
                    if (field_end()) phase = lrd_pkg::PH_FMTLEN;
                end
                lrd_pkg::PH_FMTLEN: begin
                    lbl.byte_class = lrd_pkg::CLS_HEADER;
                    fmt_len_reg = {fmt_len_reg[23:0], b};
                    if (field_end()) begin
                        remaining = fmt_len_reg;
                        phase     = (remaining != 32'd0) ? lrd_pkg::PH_FMT
                                                         : lrd_pkg::PH_PLEN;
                    end
                end
                lrd_pkg::PH_FMT: begin
                    lbl.byte_class = lrd_pkg::CLS_FMT;
                    if (remaining <= 32'd1) begin
                        remaining       = 32'd0;
                        lbl.format_last = 1'b1;
                        phase           = lrd_pkg::PH_PLEN;
                    end else begin
                        remaining = remaining - 32'd1;
                    end
                end
                lrd_pkg::PH_PLEN: begin
                    lbl.byte_class = lrd_pkg::CLS_PLEN;
                    pay_len_reg = {pay_len_reg[23:0], b};
                    if (field_end()) begin
                        remaining = pay_len_reg;
                        if (remaining == 32'd0) begin
                            lbl.record_last = 1'b1;
                            phase           = lrd_pkg::PH_HUNT;
                        end else begin
                            phase = lrd_pkg::PH_DATA;
                        end
                    end
                end
                default: begin
                    lbl.byte_class = lrd_pkg::CLS_DATA;
                    if (remaining <= 32'd1) begin
                        remaining       = 32'd0;
                        lbl.record_last = 1'b1;
                        phase           = lrd_pkg::PH_HUNT;
                    end else begin
                        remaining = remaining - 32'd1;
                    end
                end
            endcase
        end
        lbl.byte_value     = b;
        lbl.timestamp      = time_reg;
        lbl.image_width    = width_reg;
        lbl.image_height   = height_reg;
        lbl.format_length  = fmt_len_reg;
        lbl.payload_length = pay_len_reg;
        expected_labels.push_back(lbl);
    endtask

    // Driver: predict on acceptance, then offer the next item or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                deframe_byte(s_data_byte, s_end_of_stream);
                sent_count++;
            end
            if (!s_valid || s_ready) begin
                if (stream_q.size() != 0 &&
                    ((sent_count >= 300 && sent_count < 500) || $urandom_range(99) >= 17)) begin
                    next_item = stream_q.pop_front();
                    s_valid         <= 1'b1;
                    s_data_byte     <= next_item.data;
                    s_end_of_stream <= next_item.eos;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, one long hold-off, and a calm stretch
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (sink_hold > 0) begin
            sink_hold--;
            m_ready <= 1'b0;
        end else if (!sink_held && result_count >= 250) begin
            sink_held = 1'b1;
            sink_hold = 150;
            m_ready <= 1'b0;
        end else begin
            m_ready <= (result_count >= 600 && result_count < 800) ||
                       ($urandom_range(99) >= 17);
        end
    end

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Monitor: compare each accepted result with the oldest label
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            result_count <= result_count + 1;
            if (expected_labels.size() == 0) begin
                $error("unexpected result item, byte_value %0h", m_byte_value);
                mismatches++;
            end else begin
                check_field("byte_class", expected_labels[0].byte_class, m_byte_class);
                check_field("byte_value", expected_labels[0].byte_value, m_byte_value);
                check_field("timestamp", expected_labels[0].timestamp, m_timestamp);
                check_field("image_width", expected_labels[0].image_width, m_image_width);
                check_field("image_height", expected_labels[0].image_height, m_image_height);
                check_field("format_length", expected_labels[0].format_length,
                            m_format_length);
                check_field("payload_length", expected_labels[0].payload_length,
                            m_payload_length);
                check_field("format_last", expected_labels[0].format_last, m_format_last);
                check_field("record_last", expected_labels[0].record_last, m_record_last);
                check_field("record_aborted", expected_labels[0].record_aborted,
                            m_record_aborted);
                void'(expected_labels.pop_front());
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        stream_q.push_back('{data: b, eos: 1'b0});
        pushed_count++;
    endtask

    task automatic push_eos();
        stream_q.push_back('{data: 8'($urandom), eos: 1'b1});
        pushed_count++;
    endtask

    // Append n bytes of v, most significant first
    task automatic append_field(input logic [63:0] v, input int n);
        for (int i = n - 1; i >= 0; i--) record_bytes.push_back(v[8 * i +: 8]);
    endtask

    task automatic push_field(input logic [63:0] v, input int n);
        for (int i = n - 1; i >= 0; i--) push_byte(v[8 * i +: 8]);
    endtask

    // Build one record; mode 0 sends it whole (as mode 1 if a length exceeds 40),
    // 1 cuts it with end of stream, 2 truncates it silently
    task automatic send_record(input logic [63:0] ts, input logic [31:0] w,
                               input logic [31:0] h, input logic [31:0] flen,
                               input logic [31:0] plen, input int mode);
        int n_txt;
        int n_dat;
        int cut;
        int how;
        how   = mode;
        n_txt = (flen > 40) ? 40 : int'(flen);
        n_dat = (plen > 40) ? 40 : int'(plen);
        if ((flen > 40 || plen > 40) && how == 0) how = 1;
        record_bytes.delete();
        append_field(lrd_pkg::SYNC_WORD, 8);
        append_field(ts, 8);
        append_field(w, 4);
        append_field(h, 4);
        append_field(flen, 4);
        repeat (n_txt) record_bytes.push_back(8'($urandom));
        append_field(plen, 4);
        repeat (n_dat) record_bytes.push_back(8'($urandom));
        cut = (how == 0) ? record_bytes.size() : $urandom_range(record_bytes.size() - 1, 1);
        for (int i = 0; i < cut; i++) push_byte(record_bytes[i]);
        if (how == 1) push_eos();
    endtask

    function automatic logic [31:0] pick_word();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 32'd0;
        if (r == 1) return 32'hffff_ffff;
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_length(input int hi);
        int r;
        r = $urandom_range(19);
        if (r < 4) return 32'd0;
        if (r == 19) return (($urandom_range(1) == 0) ? 32'hffff_ffff : $urandom);
        return $urandom_range(hi, 1);
    endfunction

    // Mostly well-formed records, with cut records, noise and stray end of stream
    task automatic random_stream(input int target);
        int roll;
        int k;
        while (pushed_count < target) begin
            roll = $urandom_range(99);
            if (roll < 68) begin
                send_record({$urandom, $urandom}, pick_word(), pick_word(),
                            pick_length(6), pick_length(12), 0);
            end else if (roll < 80) begin
                send_record({$urandom, $urandom}, pick_word(), pick_word(),
                            pick_length(6), pick_length(12), 1);
            end else if (roll < 86) begin
                send_record({$urandom, $urandom}, pick_word(), pick_word(),
                            pick_length(6), pick_length(12), 2);
            end else if (roll < 94) begin
                // Partial magic followed by one to three random bytes
                k = $urandom_range(7);
                push_field(lrd_pkg::SYNC_WORD >> (64 - 8 * k), k);
                repeat ($urandom_range(3, 1)) push_byte(8'($urandom));
            end else begin
                push_eos();
            end
        end
    endtask

    task automatic wait_idle();
        while (stream_q.size() != 0 || s_valid || expected_labels.size() != 0)
            @(negedge aclk);
    endtask

    // Stimulus and end of run
    initial begin
        // Hunting: extremes, a broken magic that must not be re-tested, end of stream
        push_byte(8'h00);
        push_byte(8'hff);
        push_field(64'h1792, 2);
        push_field(lrd_pkg::SYNC_WORD, 8);
        push_eos();
        // Complete record with empty format text and empty payload
        push_field(lrd_pkg::SYNC_WORD, 8);
        push_field(64'hffff_ffff_ffff_ffff, 8);
        push_field(32'h0000_0000, 4);
        push_field(32'hffff_ffff, 4);
        push_field(32'd0, 4);
        push_field(32'd0, 4);
        // Abort mid-header
        push_field(lrd_pkg::SYNC_WORD, 8);
        push_field(64'h0102, 2);
        push_eos();
        // One text byte and one payload byte
        send_record(64'h8000_0000_0000_0001, 32'h1, 32'h8000_0000, 32'd1, 32'd1, 0);

        random_stream(520);
        // Let the whole pipeline drain before carrying on
        wait_idle();
        random_stream(1040);
        wait_idle();
        repeat (8) @(negedge aclk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #200us;
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* files.f */
hdl/lrd_pkg.sv
hdl/lrd_parse.sv
hdl/lrd_out_reg.sv
hdl/log_record_deframer.sv
dv/testbench.sv
